// ===== design/sbusfd_pkg.sv =====
// Shared constants and types for the SBUS frame decoder.
// No dependencies; imported by sbusfd_emitter, sbus_frame_decoder_top and the bench.
package sbusfd_pkg;

    localparam logic [7:0]  START_BYTE    = 8'h0F;
    localparam logic [7:0]  END_BYTE      = 8'h00;
    localparam int          CHAN_W        = 11;
    localparam int          PROP_CHANNELS = 16;
    localparam int          DATA_BYTES    = 22;
    localparam int          DATA_BITS     = DATA_BYTES * 8;
    localparam int          STORE_BITS    = DATA_BITS + 8;
    localparam logic [10:0] DIGITAL_ON    = 11'h7FF;
    localparam logic [4:0]  LAST_POS      = 5'd24;
    localparam logic [4:0]  IDX_DIG0      = 5'd16;
    localparam logic [4:0]  IDX_DIG1      = 5'd17;

    // Flag byte bit positions
    localparam int FLAG_DIG0 = 0;
    localparam int FLAG_DIG1 = 1;
    localparam int FLAG_LOST = 2;
    localparam int FLAG_FS   = 3;

    // Hand-over of a completed frame to the result stage
    typedef struct packed {
        logic                 valid;
        logic                 bad;
        logic [DATA_BITS-1:0] chan_data;
        logic [1:0]           digital;
        logic                 failsafe;
        logic                 frame_lost;
        logic [7:0]           lost_count;
        logic [7:0]           error_count;
    } frame_load_t;

endpackage

// ===== design/sbusfd_emitter.sv =====
// Result stage: holds one decoded frame and plays out its results one transfer at a time.
// Depends on sbusfd_pkg.
module sbusfd_emitter
    import sbusfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  frame_load_t load,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // index[4:0], value[15:5], failsafe[16], lost[17],
                                  // lost_count[25:18], error_count[33:26], zero[39:34]
    output logic [0:0]  m_tuser,  // frame_status
    output logic        m_tlast
);

    logic                 busy_reg;
    logic                 bad_reg;
    logic [4:0]           idx_reg;
    logic [DATA_BITS-1:0] chan_reg;
    logic [1:0]           dig_reg;
    logic                 fs_reg;
    logic                 lostf_reg;
    logic [7:0]           lc_reg;
    logic [7:0]           ec_reg;
    logic [CHAN_W-1:0]    value;
    logic                 last;
    logic                 take;

    assign last = bad_reg || (idx_reg == IDX_DIG1);
    assign take = busy_reg && m_tready;

    always_comb begin
        priority if (bad_reg) begin
            value = '0;
        end else if (idx_reg == IDX_DIG0) begin
            value = dig_reg[0] ? DIGITAL_ON : '0;
        end else if (idx_reg == IDX_DIG1) begin
            value = dig_reg[1] ? DIGITAL_ON : '0;
        end else begin
            value = chan_reg[CHAN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (load.valid) begin
            busy_reg <= 1'b1;
        end else if (take && last) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load.valid) begin
            bad_reg   <= load.bad;
            idx_reg   <= '0;
            chan_reg  <= load.chan_data;
            dig_reg   <= load.digital;
            fs_reg    <= load.failsafe;
            lostf_reg <= load.frame_lost;
            lc_reg    <= load.lost_count;
            ec_reg    <= load.error_count;
        end else if (take) begin
            idx_reg  <= idx_reg + 5'd1;
            // next channel moves to the bottom
            chan_reg <= {{CHAN_W{1'b0}}, chan_reg[DATA_BITS-1:CHAN_W]};
        end
    end

    assign m_tvalid = busy_reg;
    assign m_tlast  = last;
    assign m_tuser  = bad_reg;
    assign m_tdata  = {6'b0, ec_reg, lc_reg, lostf_reg, fs_reg, value, idx_reg};

endmodule

// ===== design/sbus_frame_decoder_top.sv =====
// SBUS frame decoder: one received byte per transfer in, channel results out.
// The result burst starts in the cycle after the end byte is accepted; a good frame gives
// 18 results, a bad one a single result. Throughput: one byte per cycle, except that the
// end byte waits while the previous frame's results are still draining.
// Reset (aresetn low, synchronous) clears frame position, both counts and the result stage.
// Depends on sbusfd_pkg and sbusfd_emitter.
module sbus_frame_decoder_top
    import sbusfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // channel_index[4:0], channel_value[15:5],
                                   // failsafe_flag[16], frame_lost_flag[17],
                                   // lost_count[25:18], error_count[33:26], zero[39:34]
    output logic [0:0]  m_tuser,   // frame_status
    output logic        m_tlast    // last_of_frame
);

    logic [4:0]            pos_reg;
    logic [STORE_BITS-1:0] frame_reg;   // bytes 1..23, byte 1 lowest once complete
    logic [7:0]            err_reg;
    logic [7:0]            lost_reg;
    logic                  accept;
    logic                  at_end;
    logic                  bad;
    logic [7:0]            flags;
    logic                  lost_hit;
    logic [7:0]            err_next;
    logic [7:0]            lost_next;
    frame_load_t           load;

    assign at_end   = (pos_reg == LAST_POS);
    // the end byte must wait for the result stage to empty
    assign s_tready = !at_end || !m_tvalid;
    assign accept   = s_tvalid && s_tready;

    assign bad       = (s_tdata != END_BYTE);
    assign flags     = frame_reg[STORE_BITS-1:DATA_BITS];
    assign lost_hit  = !bad && flags[FLAG_LOST];
    assign err_next  = err_reg + {7'd0, bad};
    assign lost_next = lost_reg + {7'd0, lost_hit};

    always_comb begin
        load.valid       = accept && at_end;
        load.bad         = bad;
        load.chan_data   = frame_reg[DATA_BITS-1:0];
        load.digital     = {flags[FLAG_DIG1], flags[FLAG_DIG0]};
        load.failsafe    = !bad && flags[FLAG_FS];
        load.frame_lost  = lost_hit;
        load.lost_count  = lost_next;
        load.error_count = err_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            err_reg  <= '0;
            lost_reg <= '0;
        end else if (accept) begin
            priority if (pos_reg == 5'd0) begin
                if (s_tdata == START_BYTE) begin
                    pos_reg <= 5'd1;
                end
            end else if (!at_end) begin
                pos_reg <= pos_reg + 5'd1;
            end else begin
                pos_reg  <= '0;
                err_reg  <= err_next;
                lost_reg <= lost_next;
            end
        end
    end

    // start byte is not kept; data bytes shift in from the top
    always_ff @(posedge aclk) begin
        if (accept && (pos_reg != 5'd0) && !at_end) begin
            frame_reg <= {s_tdata, frame_reg[STORE_BITS-1:8]};
        end
    end

    sbusfd_emitter u_emitter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load.valid |-> !m_tvalid)
        else $error("frame loaded while results still pending");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= LAST_POS)
        else $error("byte position out of range");

    a_bad_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> m_tlast)
        else $error("bad frame result not marked last");

    a_burst_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
        else $error("result stage still busy after last transfer");
`endif

endmodule

// ===== bench/tb_sbus_frame_decoder_top.sv =====
// Self-checking bench for sbus_frame_decoder_top: streams received bytes in, checks channel results.
// A byte-level frame decoder model predicts every result; random gaps stall both sides.
// Depends on sbusfd_pkg and the design sources.
`timescale 1ns / 100ps

module tb_sbus_frame_decoder_top;
    import sbusfd_pkg::*;

    localparam int   CYCLE_LIMIT   = 3_000_000;
    localparam int   RANDOM_BYTES  = 250;
    localparam int   TAIL_CYCLES   = 60;
    localparam int   CHANNELS      = 18;
    localparam logic STATUS_GOOD   = 1'b0;
    localparam logic STATUS_BAD    = 1'b1;

    typedef struct packed {
        logic        status;
        logic [4:0]  chan;
        logic [10:0] value;
        logic        failsafe;
        logic        lost;
        logic [7:0]  lost_cnt;
        logic [7:0]  err_cnt;
        logic        last;
    } chan_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    sbus_frame_decoder_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // decoder model state
    logic [7:0]   frame_bytes [0:23];
    logic [4:0]   frame_pos   = 5'd0;
    logic [7:0]   bad_tally   = 8'd0;
    logic [7:0]   lost_tally  = 8'd0;

    logic [7:0]   byte_queue [$];
    chan_result_t chan_queue [$];

    int bytes_sent      = 0;
    int results_checked = 0;
    int good_frames     = 0;
    int bad_frames      = 0;
    int mismatches      = 0;
    int cycle_count     = 0;
    int tx_wait         = 0;
    int tx_calm         = 0;
    int rx_wait         = 0;
    int rx_calm         = 0;

    // mostly short gaps, a few long ones, and now and then a stretch with none
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // one received byte through the frame decoder; queues the channel results it causes
    task automatic decode_byte(input logic [7:0] b);
        logic [DATA_BITS-1:0] chan_bits;
        logic [7:0]           flags;
        chan_result_t         r;
        if (frame_pos == 5'd0 && b != START_BYTE) return;
        if (frame_pos < LAST_POS) begin
            frame_bytes[frame_pos] = b;
            frame_pos = frame_pos + 5'd1;
            return;
        end
        frame_pos = 5'd0;
        if (b != END_BYTE) begin
            bad_tally = bad_tally + 8'd1;
            bad_frames++;
            r = '0;
            r.status   = STATUS_BAD;
            r.lost_cnt = lost_tally;
            r.err_cnt  = bad_tally;
            r.last     = 1'b1;
            chan_queue.push_back(r);
            return;
        end
        good_frames++;
        flags = frame_bytes[23];
        if (flags[FLAG_LOST]) lost_tally = lost_tally + 8'd1;
        for (int i = 0; i < DATA_BYTES; i++) chan_bits[8*i +: 8] = frame_bytes[i+1];
        for (int k = 0; k < CHANNELS; k++) begin
            r = '0;
            r.status   = STATUS_GOOD;
            r.chan     = 5'(k);
            r.failsafe = flags[FLAG_FS];
            r.lost     = flags[FLAG_LOST];
            r.lost_cnt = lost_tally;
            r.err_cnt  = bad_tally;
            r.last     = (r.chan == IDX_DIG1);
            if (k < PROP_CHANNELS)
                r.value = chan_bits[CHAN_W*k +: CHAN_W];
            else if (r.chan == IDX_DIG0)
                r.value = flags[FLAG_DIG0] ? DIGITAL_ON : 11'd0;
            else
                r.value = flags[FLAG_DIG1] ? DIGITAL_ON : 11'd0;
            chan_queue.push_back(r);
        end
    endtask

    task automatic queue_frame(input logic [7:0] fill, input bit scatter,
                               input logic [7:0] flag_byte, input logic [7:0] end_byte);
        byte_queue.push_back(START_BYTE);
        for (int i = 0; i < DATA_BYTES; i++)
            byte_queue.push_back(scatter ? 8'($urandom) : fill);
        byte_queue.push_back(flag_byte);
        byte_queue.push_back(end_byte);
    endtask

    // byte driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_wait  <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata);
                bytes_sent++;
            end
            if (s_tvalid && !s_tready) begin
                // hold the pending transfer
            end else if (tx_wait > 0) begin
                tx_wait  <= tx_wait - 1;
                s_tvalid <= 1'b0;
            end else if (byte_queue.size() > 0) begin
                s_tdata  <= byte_queue.pop_front();
                s_tvalid <= 1'b1;
                tx_wait  <= pick_gap(tx_calm);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        chan_result_t got, want;
        int hold;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait  <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.status   = m_tuser[0];
                got.chan     = m_tdata[4:0];
                got.value    = m_tdata[15:5];
                got.failsafe = m_tdata[16];
                got.lost     = m_tdata[17];
                got.lost_cnt = m_tdata[25:18];
                got.err_cnt  = m_tdata[33:26];
                got.last     = m_tlast;
                if (chan_queue.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: result with nothing expected: st=%0d ch=%0d val=%0d",
                                 $realtime, got.status, got.chan, got.value);
                    mismatches++;
                end else begin
                    want = chan_queue.pop_front();
                    results_checked++;
                    if (got !== want) begin
                        if (mismatches < 10)
                            $display({"%0t: mismatch st/ch/val/fs/lost/lcnt/ecnt/last ",
                                      "exp %0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d ",
                                      "got %0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d"}, $realtime,
                                     want.status, want.chan, want.value, want.failsafe,
                                     want.lost, want.lost_cnt, want.err_cnt, want.last,
                                     got.status, got.chan, got.value, got.failsafe,
                                     got.lost, got.lost_cnt, got.err_cnt, got.last);
                        mismatches++;
                    end
                end
                hold = pick_gap(rx_calm);
            end else if (rx_wait > 0) begin
                hold = rx_wait - 1;
            end else begin
                // occasional stall while nothing is moving too
                hold = ($urandom_range(0, 9) == 0) ? pick_gap(rx_calm) : 0;
            end
            rx_wait  <= hold;
            m_tready <= (hold == 0);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, chan_queue.size());
            $display("sbus_frame_decoder_top verification failed");
            $finish;
        end
    end

    initial begin
        int pick;
        int n;
        int random_bytes;
        logic [7:0] tail;

        // idle noise, including the byte just below the start code
        byte_queue.push_back(8'h00);
        byte_queue.push_back(8'hFF);
        byte_queue.push_back(8'h0E);
        byte_queue.push_back(8'h10);
        // all data and flag bits set, upper flag bits too
        queue_frame(8'hFF, 1'b0, 8'hFF, END_BYTE);
        // zero data, only the ignored upper flag bits set
        queue_frame(8'h00, 1'b0, 8'hF0, END_BYTE);
        // start code as payload must not resynchronise
        queue_frame(START_BYTE, 1'b0, 8'h05, END_BYTE);
        // bad end bytes, whose flags are discarded; then random data with digital channel 1 set
        queue_frame(8'hA5, 1'b0, 8'h0A, 8'h80);
        queue_frame(8'h5A, 1'b0, 8'h0F, START_BYTE);
        queue_frame(8'h00, 1'b1, 8'h02, END_BYTE);

        random_bytes = 0;
        while (random_bytes < RANDOM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                tail = ($urandom_range(0, 99) < 85) ? END_BYTE : 8'($urandom_range(1, 255));
                queue_frame(8'h00, 1'b1, 8'($urandom), tail);
                random_bytes += 25;
            end else if (pick < 85) begin
                n = $urandom_range(1, 3);
                repeat (n) byte_queue.push_back(8'($urandom));
                random_bytes += n;
            end else begin
                // truncated frame: the next bytes get swallowed into it
                byte_queue.push_back(START_BYTE);
                n = $urandom_range(0, 23);
                repeat (n) byte_queue.push_back(8'($urandom));
                random_bytes += n + 1;
            end
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        @(posedge aclk);
        while (byte_queue.size() > 0 || s_tvalid || chan_queue.size() > 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("sent %0d bytes: %0d good and %0d dropped frames, %0d results checked",
                 bytes_sent, good_frames, bad_frames, results_checked);
        $display("lost count ended at %0d, error count at %0d, %0d mismatches",
                 lost_tally, bad_tally, mismatches);
        if (mismatches == 0 && chan_queue.size() == 0)
            $display("sbus_frame_decoder_top verification clean");
        else
            $display("sbus_frame_decoder_top verification failed");
        $finish;
    end

endmodule
